FILE: hdl/rpd_pkg.sv
// Shared types and the escape pair table for the restricted percent decoder.
// Depends on nothing; imported by restricted_percent_decoder_top.
`default_nettype none

package rpd_pkg;

  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] PercentChar = 8'h25;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_final;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             bad_escape;
    logic             out_final;
  } out_beat_t;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ch;
  } pair_hit_t;

  // Match an uppercase hex pair against the fixed set of 26 escapes.
  function automatic pair_hit_t pair_lookup(input logic [CharW-1:0] hi,
                                            input logic [CharW-1:0] lo);
    pair_hit_t r;
    r.hit = 1'b1;
    r.ch  = '0;
    unique case ({hi, lo})
      {8'h32, 8'h30}: r.ch = 8'h20; // "20" space
      {8'h32, 8'h34}: r.ch = 8'h24; // "24" $
      {8'h32, 8'h36}: r.ch = 8'h26; // "26" &
      {8'h36, 8'h30}: r.ch = 8'h60; // "60" backquote
      {8'h33, 8'h41}: r.ch = 8'h3A; // "3A" :
      {8'h33, 8'h43}: r.ch = 8'h3C; // "3C" <
      {8'h33, 8'h45}: r.ch = 8'h3E; // "3E" >
      {8'h35, 8'h42}: r.ch = 8'h5B; // "5B" [
      {8'h35, 8'h44}: r.ch = 8'h5D; // "5D" ]
      {8'h37, 8'h42}: r.ch = 8'h7B; // "7B" {
      {8'h37, 8'h44}: r.ch = 8'h7D; // "7D" }
      {8'h32, 8'h32}: r.ch = 8'h22; // "22" double quote
      {8'h32, 8'h42}: r.ch = 8'h2B; // "2B" +
      {8'h32, 8'h33}: r.ch = 8'h23; // "23" #
      {8'h32, 8'h35}: r.ch = 8'h25; // "25" percent
      {8'h34, 8'h30}: r.ch = 8'h40; // "40" @
      {8'h32, 8'h46}: r.ch = 8'h2F; // "2F" /
      {8'h33, 8'h42}: r.ch = 8'h3B; // "3B" ;
      {8'h33, 8'h44}: r.ch = 8'h3D; // "3D" =
      {8'h33, 8'h46}: r.ch = 8'h3F; // "3F" ?
      {8'h35, 8'h43}: r.ch = 8'h5C; // "5C" backslash
      {8'h35, 8'h45}: r.ch = 8'h5E; // "5E" ^
      {8'h37, 8'h43}: r.ch = 8'h7C; // "7C" |
      {8'h37, 8'h45}: r.ch = 8'h7E; // "7E" ~
      {8'h32, 8'h37}: r.ch = 8'h27; // "27" single quote
      {8'h32, 8'h43}: r.ch = 8'h2C; // "2C" ,
      default:        r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/restricted_percent_decoder_top.sv
// Restricted percent decoder: input register, escape logic, result register.
// Depends on rpd_pkg (beat structs, phase enum, pair table).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | sink      | in_valid_i / in_stall_o  | in_beat_t  (char, final)
//   out     | source    | out_valid_o / out_stall_i| out_beat_t (char, bad, final)
//
// One byte per cycle sustained while the output is not stalled. A beat waits in
// the input register and moves into the result register when that is free; only
// a byte with a result sets out_valid_o. Unless final, the escape opener and
// first pair byte produce no result; after an error, bytes are dropped until
// the final byte. The result register takes a new result whenever it is empty
// or being read, so a stall on the output backs up through the input register.
// Reset clears the escape phase, the error flag and both valid bits.
`default_nettype none

module restricted_percent_decoder_top
  import rpd_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  wire in_beat_t in_data_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output out_beat_t out_data_o
);

  logic             s1_valid_q, s1_valid_d;
  in_beat_t         s1_beat_q;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_beat_q;
  phase_e           phase_q, phase_d;
  logic [CharW-1:0] first_q, first_d;
  logic             err_q, err_d;

  logic      out_free, s1_adv, in_accept;
  logic      res_valid;
  out_beat_t res;
  pair_hit_t pair;

  // Result register can load when empty or drained this cycle.
  assign out_free   = !(out_valid_q && out_stall_i);
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pair = pair_lookup(first_q, s1_beat_q.in_char);

  // Escape decode for the beat in the input register.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    phase_d   = phase_q;
    first_d   = first_q;
    err_d     = err_q;
    if (s1_adv) begin
      if (err_q) begin
        // drop bytes until the final one, which reports the error again
        if (s1_beat_q.in_final) begin
          res_valid      = 1'b1;
          res.bad_escape = 1'b1;
          res.out_final  = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_PCT: begin
            if (s1_beat_q.in_final) begin
              res_valid      = 1'b1;
              res.bad_escape = 1'b1;
              res.out_final  = 1'b1;
            end else begin
              first_d = s1_beat_q.in_char;
              phase_d = PH_HEX;
            end
          end
          PH_HEX: begin
            res_valid     = 1'b1;
            res.out_final = s1_beat_q.in_final;
            first_d       = '0;
            phase_d       = PH_IDLE;
            if (pair.hit) begin
              res.out_char = pair.ch;
            end else begin
              res.bad_escape = 1'b1;
              err_d          = !s1_beat_q.in_final;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            if (s1_beat_q.in_char == PercentChar) begin
              if (s1_beat_q.in_final) begin
                res_valid      = 1'b1;
                res.bad_escape = 1'b1;
                res.out_final  = 1'b1;
              end else begin
                phase_d = PH_PCT;
              end
            end else begin
              res_valid     = 1'b1;
              res.out_char  = s1_beat_q.in_char;
              res.out_final = s1_beat_q.in_final;
            end
          end
        endcase
      end
      // final byte returns every piece of string state to reset
      if (s1_beat_q.in_final) begin
        phase_d = PH_IDLE;
        first_d = '0;
        err_d   = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_adv && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      first_q     <= '0;
      err_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      first_q     <= first_d;
      err_q       <= err_d;
    end
  end

  // Payload registers: input loads on accept, result loads on a new result; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_beat_q <= in_data_i;
    end
    if (s1_adv && res_valid) begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

`ifndef NO_ASSERTIONS
  a_err_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_escape |-> out_data_o.out_char == '0)
    else $error("error result carries a nonzero character");

  a_err_outside_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> phase_q == PH_IDLE)
    else $error("error latched while inside an escape");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_beat_q.in_final |=> phase_q == PH_IDLE && !err_q && first_q == '0)
    else $error("string state not cleared after final byte");

  a_final_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_beat_q.in_final |=> out_valid_q && out_beat_q.out_final)
    else $error("final byte produced no end-marked result");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with nothing held");
`endif

endmodule

`default_nettype wire

FILE: sim/restricted_percent_decoder_top_tb.sv
// Self-checking testbench for restricted_percent_decoder_top: a directed table
// of request strings, then random strings, scored against a local decoder or hand-typed rows.
// Depends on rpd_pkg and hdl/restricted_percent_decoder_top.sv.
`timescale 1ns / 100ps

module restricted_percent_decoder_top_tb;
  import rpd_pkg::*;

  localparam int unsigned PAIR_COUNT   = 26;
  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned PROBE_ROWS   = 24;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned REPORT_CAP   = 40;

  // Accepted escape pairs as ASCII text, two characters per entry, and the
  // byte each one stands for, in the same order.
  localparam logic [PAIR_COUNT*16-1:0] PAIR_TEXT =
    "202426603A3C3E5B5D7B7D222B2325402F3B3D3F5C5E7C7E272C";
  localparam logic [PAIR_COUNT*8-1:0] PAIR_BYTE =
    208'h202426603A3C3E5B5D7B7D222B2325402F3B3D3F5C5E7C7E272C;

  // One row of the directed table: the beat to send, and, where the result
  // is obvious, the result typed in by hand.
  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t res;
  } probe_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_r  = 1'b0;
  in_beat_t  in_beat_r   = '0;
  logic      out_stall_r = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_data_o;

  // Decoder state mirrored by the testbench.
  phase_e      esc_phase = PH_IDLE;
  logic [7:0]  held_hi   = '0;
  bit          err_hold  = 1'b0;

  out_beat_t   pending_results[$];
  out_beat_t   head_result;
  bit          quiet = 1'b0;     // when set, both sides run without idling
  int unsigned err_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;

  restricted_percent_decoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_beat_r),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_r),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hold reset from time zero, then release it away from the sampling edge.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Bail out if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("** restricted_percent_decoder_top: FAILED **");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    if (err_count < REPORT_CAP)
      $display("[%0t] MISMATCH: %s", $realtime, what);
    err_count++;
  endtask

  // Escape pair i as its two ASCII characters.
  function automatic logic [15:0] pair_text(input int unsigned i);
    return PAIR_TEXT[(PAIR_COUNT-1-i)*16 +: 16];
  endfunction

  // Advance the mirrored decoder by one byte; return 1 when the byte
  // produces a result, which lands in res.
  function automatic bit decode_step(input in_beat_t b, output out_beat_t res);
    bit         hit;
    logic [7:0] mapped;
    res    = '0;
    hit    = 1'b0;
    mapped = '0;
    // After an error, drop everything until the last byte closes the string.
    if (err_hold) begin
      if (!b.in_final)
        return 1'b0;
      err_hold       = 1'b0;
      esc_phase      = PH_IDLE;
      held_hi        = '0;
      res.bad_escape = 1'b1;
      res.out_final  = 1'b1;
      return 1'b1;
    end
    case (esc_phase)
      PH_PCT: begin
        if (b.in_final) begin
          // Escape cut short right after the opener.
          esc_phase      = PH_IDLE;
          held_hi        = '0;
          res.bad_escape = 1'b1;
          res.out_final  = 1'b1;
          return 1'b1;
        end
        held_hi   = b.in_char;
        esc_phase = PH_HEX;
        return 1'b0;
      end
      PH_HEX: begin
        for (int i = 0; i < PAIR_COUNT; i++) begin
          if (pair_text(i) == {held_hi, b.in_char}) begin
            hit    = 1'b1;
            mapped = PAIR_BYTE[(PAIR_COUNT-1-i)*8 +: 8];
          end
        end
        esc_phase     = PH_IDLE;
        held_hi       = '0;
        res.out_final = b.in_final;
        if (hit) begin
          res.out_char = mapped;
        end else begin
          res.bad_escape = 1'b1;
          err_hold       = !b.in_final;
        end
        return 1'b1;
      end
      default: begin
        esc_phase = PH_IDLE;
        if (b.in_char == PercentChar) begin
          if (b.in_final) begin
            res.bad_escape = 1'b1;
            res.out_final  = 1'b1;
            return 1'b1;
          end
          esc_phase = PH_PCT;
          return 1'b0;
        end
        res.out_char  = b.in_char;
        res.out_final = b.in_final;
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one beat after a random gap, wait for it to be taken, then log
  // what it should produce.
  task automatic send_byte(input in_beat_t b, input bit typed, input out_beat_t typed_res);
    out_beat_t   res;
    bit          has_res;
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_r <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_r <= 1'b1;
    in_beat_r  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    has_res = decode_step(b, res);
    // Trust the hand-typed result on table rows that carry one; the mirror
    // still advances so that later rows line up.
    if (typed)
      pending_results.push_back(typed_res);
    else if (has_res)
      pending_results.push_back(res);
    bytes_sent++;
  endtask

  // Drop valid and hold off until every owed result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_r <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Build one random request string and send it. Most strings are well
  // formed with random content; some carry broken or truncated escapes,
  // and noisy ones are plain random bytes.
  task automatic send_string(input int unsigned len, input bit noisy);
    logic [7:0]  seq[$];
    logic [15:0] code;
    in_beat_t    b;
    int unsigned pick;
    bit          cut;
    cut = 1'b0;
    while (seq.size() < len && !cut) begin
      pick = noisy ? 0 : $urandom_range(0, 99);
      code = pair_text($urandom_range(0, PAIR_COUNT-1));
      if (pick < 60) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        seq.push_back(PercentChar);
        seq.push_back(code[15:8]);
        seq.push_back(code[7:0]);
      end else begin
        seq.push_back(PercentChar);
        case ($urandom_range(0, 2))
          0: begin
            seq.push_back(8'($urandom_range(0, 255)));
            seq.push_back(8'($urandom_range(0, 255)));
          end
          // Lowercase the second digit; digits keep their value.
          1: begin
            seq.push_back(code[15:8]);
            seq.push_back(code[7:0] | 8'h20);
          end
          // End the string inside the escape.
          default: begin
            if ($urandom_range(0, 1) != 0)
              seq.push_back(code[15:8]);
            cut = 1'b1;
          end
        endcase
      end
    end
    foreach (seq[i]) begin
      b.in_char  = seq[i];
      b.in_final = (i == seq.size() - 1);
      send_byte(b, 1'b0, '0);
    end
    strings_sent++;
  endtask

  // Receiver: stall for a random gap before each result, then take it.
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 11);
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_r <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_r <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Score every result beat against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_r) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat char=%h bad=%b final=%b",
                                out_data_o.out_char, out_data_o.bad_escape,
                                out_data_o.out_final));
      end else begin
        head_result = pending_results.pop_front();
        if (out_data_o.out_char !== head_result.out_char)
          flag_mismatch($sformatf("out_char %h, want %h", out_data_o.out_char,
                                  head_result.out_char));
        if (out_data_o.bad_escape !== head_result.bad_escape)
          flag_mismatch($sformatf("bad_escape %b, want %b", out_data_o.bad_escape,
                                  head_result.bad_escape));
        if (out_data_o.out_final !== head_result.out_final)
          flag_mismatch($sformatf("out_final %b, want %b", out_data_o.out_final,
                                  head_result.out_final));
        if (head_result.bad_escape)
          bad_results++;
      end
      results_seen++;
    end
  end

  function automatic probe_row_t mirror_row(input logic [7:0] c, input logic fin);
    probe_row_t r;
    r = '0;
    r.beat.in_char  = c;
    r.beat.in_final = fin;
    return r;
  endfunction

  function automatic probe_row_t typed_row(input logic [7:0] c, input logic fin,
                                           input logic [7:0] oc, input logic bad,
                                           input logic ofin);
    probe_row_t r;
    r                = mirror_row(c, fin);
    r.typed          = 1'b1;
    r.res.out_char   = oc;
    r.res.bad_escape = bad;
    r.res.out_final  = ofin;
    return r;
  endfunction

  initial begin : stimulus
    probe_row_t rows [PROBE_ROWS];
    bit         paused;
    paused = 1'b0;
    rows = '{
      // plain bytes at the extremes, zero included
      typed_row("A",   1'b0, "A",   1'b0, 1'b0),
      typed_row(8'h00, 1'b0, 8'h00, 1'b0, 1'b0),
      typed_row(8'hFF, 1'b0, 8'hFF, 1'b0, 1'b0),
      // %20 decodes to a space
      mirror_row("%", 1'b0), mirror_row("2", 1'b0), mirror_row("0", 1'b0),
      // %25 decodes to a percent, which is data and opens nothing
      mirror_row("%", 1'b0), mirror_row("2", 1'b0), mirror_row("5", 1'b0),
      // %7E on the last byte closes the string
      mirror_row("%", 1'b0), mirror_row("7", 1'b0), mirror_row("E", 1'b1),
      // escape cut short right after the opener
      typed_row("%", 1'b1, 8'h00, 1'b1, 1'b1),
      // escape cut short after one digit
      mirror_row("%", 1'b0),
      typed_row("3", 1'b1, 8'h00, 1'b1, 1'b1),
      // lowercase hex is an error; the rest is dropped up to the last byte
      mirror_row("%", 1'b0), mirror_row("3", 1'b0),
      typed_row("a", 1'b0, 8'h00, 1'b1, 1'b0),
      mirror_row("%", 1'b0),
      typed_row("y", 1'b1, 8'h00, 1'b1, 1'b1),
      // zero byte inside a pair, unknown pair on the last byte
      mirror_row("%", 1'b0), mirror_row(8'h00, 1'b0),
      typed_row("0", 1'b1, 8'h00, 1'b1, 1'b1),
      // a fresh string after the error
      typed_row("z", 1'b1, "z", 1'b0, 1'b1)
    };

    @(posedge rst_ni);
    foreach (rows[i])
      send_byte(rows[i].beat, rows[i].typed, rows[i].res);
    strings_sent += 6;
    drain_results();

    while (bytes_sent < PROBE_ROWS + RANDOM_BYTES) begin
      // Run about a quarter of the strings back to back with no idling.
      quiet = ($urandom_range(0, 3) == 0);
      send_string($urandom_range(1, 12), $urandom_range(0, 6) == 0);
      if (!paused && bytes_sent >= PROBE_ROWS + RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    @(negedge clk_i);
    in_valid_r <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d bytes in %0d strings; %0d results checked, %0d of them errors",
             bytes_sent, strings_sent, results_seen, bad_results);
    $display("%0d mismatches in %0d cycles", err_count, cycle_count);
    if (err_count == 0) begin
      $display("** restricted_percent_decoder_top: PASSED **");
    end else begin
      $display("** restricted_percent_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
